FILE: src/lzd_pkg.sv
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared types, constants and the 5-bit to 8-bit channel expansion table of
// the LZ RGB555 texture decompressor.
// ----------------------------------------------------------------------------
package lzd_pkg;

  // Pixel history window
  localparam int unsigned HIST_DEPTH = 2048;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned HIST_W     = 32;
  localparam int unsigned FILL_W     = $clog2(HIST_DEPTH + 1);

  // Queue depths
  localparam int unsigned CMD_FIFO_DEPTH = 2;
  localparam int unsigned OUT_FIFO_DEPTH = 2;

  // Configuration registers
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SWAP_RB     = 1'b0,
    REG_PIXEL_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    TOK_LIT,
    TOK_COPY,
    TOK_RUN,
    TOK_ZERO
  } tok_kind_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_COPY_RD,
    BS_COPY_WR,
    BS_SWEEP
  } back_state_e;

  // Decoded token handed from the front to the back
  typedef struct packed {
    tok_kind_e   kind;
    logic [7:0]  pix_first;
    logic [7:0]  pix_middle;
    logic [7:0]  pix_last;
    logic [2:0]  reps_m2;
    logic [10:0] dist_m1;
    logic [13:0] run;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [7:0]  chan_first;
    logic [7:0]  chan_middle;
    logic [7:0]  chan_last;
    logic [7:0]  alpha;
    logic [13:0] run_length;
    logic        last;
    logic        image_done;
  } res_t;

  // round(x * 255 / 31) for every 5-bit channel value
  localparam logic [7:0] EXPAND5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
    8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
    8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
    8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
  };

  function automatic logic [7:0] expand5(input logic [4:0] x);
    return EXPAND5[x];
  endfunction

endpackage

FILE: src/lzd_ram.sv
// ----------------------------------------------------------------------------
// lzd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lzd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/lzd_fifo.sv
// ----------------------------------------------------------------------------
// lzd_fifo
// Small first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module lzd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    count_d = count_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: src/lzd_front.sv
// ----------------------------------------------------------------------------
// lzd_front
// Takes in code words, classifies each token, expands its literal colour and
// queues the decoded token for the back end.
// ----------------------------------------------------------------------------
module lzd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [15:0]   code_word_i,
  input  logic          swap_rb_i,
  input  logic          cmd_pop_i,
  output logic          cmd_empty_o,
  output lzd_pkg::cmd_t cmd_o
);
  import lzd_pkg::*;

  cmd_t       cmd;
  logic [7:0] exp_hi, exp_mid, exp_lo;

  assign exp_hi  = expand5(code_word_i[14:10]);
  assign exp_mid = expand5(code_word_i[9:5]);
  assign exp_lo  = expand5(code_word_i[4:0]);

  always_comb begin
    if (code_word_i[15]) begin
      cmd.kind = TOK_LIT;
    end else if (code_word_i[14]) begin
      cmd.kind = TOK_COPY;
    end else if (code_word_i[13:0] != '0) begin
      cmd.kind = TOK_RUN;
    end else begin
      cmd.kind = TOK_ZERO;
    end
    // Every word carries its literal colour, as the first word of an image
    // is a literal whatever its top bits say.
    cmd.pix_first  = swap_rb_i ? exp_lo : exp_hi;
    cmd.pix_middle = exp_mid;
    cmd.pix_last   = swap_rb_i ? exp_hi : exp_lo;
    cmd.reps_m2    = code_word_i[13:11];
    cmd.dist_m1    = code_word_i[10:0];
    cmd.run        = code_word_i[13:0];
  end

  lzd_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .empty_o (cmd_empty_o),
    .rdata_o (cmd_o)
  );

endmodule

FILE: src/lzd_back.sv
// ----------------------------------------------------------------------------
// lzd_back
// Carries out decoded tokens: emits literals, copies pixels from the history
// window, sweeps zero runs into the window and tracks the image pixel count.
// ----------------------------------------------------------------------------
module lzd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_empty_i,
  input  lzd_pkg::cmd_t                 cmd_i,
  output logic                          cmd_pop_o,
  input  logic [lzd_pkg::CFG_DATA_W-1:0] pixel_count_i,
  input  logic                          pop,
  output logic                          empty_o,
  output lzd_pkg::res_t                 res_o
);
  import lzd_pkg::*;

  back_state_e        state_q, state_d;
  logic [HIST_AW-1:0] wp_q, wp_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [31:0]        emitted_q, emitted_d;
  logic               first_q, first_d;
  logic [3:0]         reps_q, reps_d;
  logic [10:0]        dist_q, dist_d;
  logic [HIST_AW-1:0] sw_addr_q, sw_addr_d;
  logic [FILL_W-1:0]  sw_cnt_q, sw_cnt_d;
  logic [HIST_AW-1:0] wp_end_q, wp_end_d;
  logic               valid_q, valid_d;

  logic [31:0]        total, rem, diff, run_w;
  logic               borrow, one_done, run_done;
  logic [13:0]        run_n;
  logic [FILL_W-1:0]  fill_inc;

  logic               ram_we, ram_re;
  logic [HIST_AW-1:0] ram_waddr, ram_raddr;
  logic [HIST_W-1:0]  ram_wdata, ram_rdata, copy_pix;

  logic               res_push, out_full;
  res_t               res;

  // Pixels still allowed in this image, at least one
  assign total          = (pixel_count_i == '0) ? 32'd1 : pixel_count_i;
  assign {borrow, diff} = {1'b0, total} - {1'b0, emitted_q};
  assign rem            = (borrow || diff == '0) ? 32'd1 : diff;
  assign one_done       = (rem == 32'd1);
  assign run_w          = 32'(cmd_i.run);
  assign run_done       = (run_w >= rem);
  assign run_n          = run_done ? rem[13:0] : cmd_i.run;
  assign fill_inc       = (fill_q == FILL_W'(HIST_DEPTH)) ? fill_q : fill_q + FILL_W'(1);
  assign copy_pix       = valid_q ? ram_rdata : '0;

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    fill_d    = fill_q;
    emitted_d = emitted_q;
    first_d   = first_q;
    reps_d    = reps_q;
    dist_d    = dist_q;
    sw_addr_d = sw_addr_q;
    sw_cnt_d  = sw_cnt_q;
    wp_end_d  = wp_end_q;
    valid_d   = valid_q;
    cmd_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wp_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = wp_q - dist_q - HIST_AW'(1);
    res_push  = 1'b0;
    res       = '0;

    case (state_q)
      BS_IDLE: begin
        if (!cmd_empty_i) begin
          if (first_q || cmd_i.kind == TOK_LIT) begin
            if (!out_full) begin
              cmd_pop_o       = 1'b1;
              res_push        = 1'b1;
              res.chan_first  = cmd_i.pix_first;
              res.chan_middle = cmd_i.pix_middle;
              res.chan_last   = cmd_i.pix_last;
              res.alpha       = 8'hFF;
              res.run_length  = 14'd1;
              res.last        = 1'b1;
              res.image_done  = one_done;
              ram_we          = 1'b1;
              ram_wdata       = {8'hFF, cmd_i.pix_last, cmd_i.pix_middle, cmd_i.pix_first};
              wp_d            = wp_q + HIST_AW'(1);
              fill_d          = fill_inc;
              emitted_d       = one_done ? '0 : emitted_q + 32'd1;
              first_d         = one_done;
            end
          end else begin
            case (cmd_i.kind)
              TOK_COPY: begin
                cmd_pop_o = 1'b1;
                reps_d    = {1'b0, cmd_i.reps_m2} + 4'd1;
                dist_d    = cmd_i.dist_m1;
                state_d   = BS_COPY_RD;
              end
              TOK_RUN: begin
                if (!out_full) begin
                  cmd_pop_o      = 1'b1;
                  res_push       = 1'b1;
                  res.run_length = run_n;
                  res.last       = 1'b1;
                  res.image_done = run_done;
                  emitted_d      = run_done ? '0 : emitted_q + run_w;
                  first_d        = run_done ? 1'b1 : first_q;
                  sw_addr_d      = wp_q;
                  sw_cnt_d       = (32'(run_n) >= HIST_DEPTH) ? FILL_W'(HIST_DEPTH)
                                                              : FILL_W'(run_n);
                  wp_end_d       = wp_q + run_n[HIST_AW-1:0];
                  state_d        = BS_SWEEP;
                end
              end
              default: begin
                // A zero word inside an image produces nothing.
                cmd_pop_o = 1'b1;
              end
            endcase
          end
        end
      end

      BS_COPY_RD: begin
        // Entries at or beyond the fill mark were never written and read as zero.
        ram_re  = 1'b1;
        valid_d = (FILL_W'(ram_raddr) < fill_q);
        state_d = BS_COPY_WR;
      end

      BS_COPY_WR: begin
        if (!out_full) begin
          res_push        = 1'b1;
          res.chan_first  = copy_pix[7:0];
          res.chan_middle = copy_pix[15:8];
          res.chan_last   = copy_pix[23:16];
          res.alpha       = copy_pix[31:24];
          res.run_length  = 14'd1;
          res.last        = (reps_q == '0) || one_done;
          res.image_done  = one_done;
          ram_we          = 1'b1;
          ram_wdata       = copy_pix;
          wp_d            = wp_q + HIST_AW'(1);
          fill_d          = fill_inc;
          emitted_d       = one_done ? '0 : emitted_q + 32'd1;
          first_d         = one_done ? 1'b1 : first_q;
          if (reps_q == '0 || one_done) begin
            state_d = BS_IDLE;
          end else begin
            reps_d  = reps_q - 4'd1;
            state_d = BS_COPY_RD;
          end
        end
      end

      BS_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sw_addr_q;
        ram_wdata = '0;
        sw_addr_d = sw_addr_q + HIST_AW'(1);
        sw_cnt_d  = sw_cnt_q - FILL_W'(1);
        fill_d    = fill_inc;
        if (sw_cnt_q == FILL_W'(1)) begin
          wp_d    = wp_end_q;
          state_d = BS_IDLE;
        end
      end

      default: begin
        state_d = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BS_IDLE;
      wp_q      <= '0;
      fill_q    <= '0;
      emitted_q <= '0;
      first_q   <= 1'b1;
      reps_q    <= '0;
      sw_cnt_q  <= '0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      fill_q    <= fill_d;
      emitted_q <= emitted_d;
      first_q   <= first_d;
      reps_q    <= reps_d;
      sw_cnt_q  <= sw_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q    <= dist_d;
    sw_addr_q <= sw_addr_d;
    wp_end_q  <= wp_end_d;
    valid_q   <= valid_d;
  end

  lzd_ram #(
    .WIDTH(HIST_W),
    .DEPTH(HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lzd_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (out_full),
    .pop_i   (pop),
    .empty_o (empty_o),
    .rdata_o (res_o)
  );

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(HIST_DEPTH))
    else $error("history fill mark beyond window depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_IDLE && fill_q != FILL_W'(HIST_DEPTH)) |->
      (wp_q == fill_q[HIST_AW-1:0]))
    else $error("write pointer left the filled prefix of the window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !out_full)
    else $error("result pushed into a full output queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res.image_done) |-> res.last)
    else $error("image end not marked as the last result of its word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_SWEEP) |-> (sw_cnt_q != '0))
    else $error("zero-run sweep entered with nothing to clear");
`endif

endmodule

FILE: src/lz_rgb555_texture_decompressor.sv
// ----------------------------------------------------------------------------
// lz_rgb555_texture_decompressor
// Expands 16-bit LZ code words into RGBA pixels with a 2048-pixel history.
// ----------------------------------------------------------------------------
// Code words enter through a queue-style port: a word is taken when push is
// high and full is low. Results leave the same way: while empty is low the
// oldest result is on the output ports, and pop takes it. The user is bound to
// write configuration through cfg_we_i, cfg_addr_i and cfg_wdata_i only while
// the block is idle; the block itself does not enforce this.
//
// One literal can follow another every cycle while the output queue has
// room. A back-reference first takes its token; each copied pixel is then
// read from the history RAM and then emitted and written back at the write
// pointer. A zero run gives its single result when its token is taken and
// then occupies the back end while it clears window entries, at most 2048.
// A two-entry queue between front and back keeps words coming in meanwhile,
// and a zero word inside an image is taken without a result.
//
// Reset empties both queues and starts a new image. The history is not
// cleared: a fill mark makes entries never written since reset read as zero.
// When the receiver stops popping, results wait in the output queue and the
// back end stalls on its next result until there is room, with nothing lost.
// ----------------------------------------------------------------------------
module lz_rgb555_texture_decompressor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lzd_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [lzd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           push,
  output logic                           full,
  input  logic [15:0]                    code_word_i,
  input  logic                           pop,
  output logic                           empty,
  output logic [7:0]                     chan_first_o,
  output logic [7:0]                     chan_middle_o,
  output logic [7:0]                     chan_last_o,
  output logic [7:0]                     alpha_o,
  output logic [13:0]                    run_length_o,
  output logic                           last_o,
  output logic                           image_done_o
);
  import lzd_pkg::*;

  logic                  swap_rb_q, swap_rb_d;
  logic [CFG_DATA_W-1:0] pixel_count_q, pixel_count_d;
  logic                  cmd_pop, cmd_empty;
  cmd_t                  cmd;
  res_t                  res;

  always_comb begin
    swap_rb_d     = swap_rb_q;
    pixel_count_d = pixel_count_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_SWAP_RB:     swap_rb_d     = cfg_wdata_i[0];
        REG_PIXEL_COUNT: pixel_count_d = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_rb_q     <= 1'b0;
      pixel_count_q <= CFG_DATA_W'(1);
    end else begin
      swap_rb_q     <= swap_rb_d;
      pixel_count_q <= pixel_count_d;
    end
  end

  lzd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .code_word_i (code_word_i),
    .swap_rb_i   (swap_rb_q),
    .cmd_pop_i   (cmd_pop),
    .cmd_empty_o (cmd_empty),
    .cmd_o       (cmd)
  );

  lzd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_empty_i   (cmd_empty),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .pixel_count_i (pixel_count_q),
    .pop           (pop),
    .empty_o       (empty),
    .res_o         (res)
  );

  assign chan_first_o  = res.chan_first;
  assign chan_middle_o = res.chan_middle;
  assign chan_last_o   = res.chan_last;
  assign alpha_o       = res.alpha;
  assign run_length_o  = res.run_length;
  assign last_o        = res.last;
  assign image_done_o  = res.image_done;

endmodule
